// ----- design/hdlc_frame_transmitter_defines.svh -----
// Assertion macros shared by the checker of the HDLC frame transmitter.
// Both sample on the rising edge of clk and are switched off while rst is high.
`ifndef HDLC_FRAME_TRANSMITTER_DEFINES_SVH
`define HDLC_FRAME_TRANSMITTER_DEFINES_SVH

// Same-cycle implication.
`define HFT_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/hdlc_pkg.sv -----
package hdlc_pkg;

  // Which part of the frame the serialiser is sending for the current item.
  typedef enum logic [2:0] {
    PH_OPEN,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } phase_t;

  localparam logic       MODE_SYNC  = 1'b0;
  localparam logic       MODE_ASYNC = 1'b1;

  localparam logic [7:0]  FLAG_CHAR  = 8'h7E;
  localparam logic [7:0]  ESC_CHAR   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] FCS_PRESET = 16'hFFFF;
  localparam logic [15:0] FCS_POLY   = 16'h8408;
  localparam logic [2:0]  STUFF_RUN  = 3'd5;

  // Reflected CCITT CRC over one byte, least significant bit first.
  function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] c;
    c = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/hdlc_frame_transmitter.sv -----
// Channel      | Handshake                 | Payload
// -------------+---------------------------+--------------------------------------
// frame input  | data_valid / data_stall   | data_byte[7:0], last_byte
// line output  | result_valid/result_stall | out_value[7:0], out_is_char, out_last
// config write | cfg_wr_en                 | cfg_wr_data (transmission_mode)
//
// One result leaves per cycle unless result_stall is high. In bit-synchronous mode a byte
// gives one result per line bit plus up to two stuffed zeros, an opening flag leads a frame and
// a closing item adds two FCS bytes and the closing flag. In asynchronous mode results are characters.
// The next item is taken in the cycle in which the current item's final result is produced.
// Reset (rst, synchronous) clears the FCS to all ones, the stuffing run, the line level and
// the frame state. An output stall holds the result register, the serialiser and the input.
module hdlc_frame_transmitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_value,
  output logic       out_is_char,
  output logic       out_last
);
  import hdlc_pkg::*;

  // Configuration.
  logic        mode;

  // Item being serialised.
  logic        busy, busy_next;
  logic [7:0]  work_byte;
  logic        work_last;
  phase_t      phase, phase_next;
  logic [2:0]  bit_idx, bit_idx_next;
  logic        stuff_pending, stuff_pending_next;
  logic        esc_pending, esc_pending_next;

  // Frame state.
  logic [15:0] fcs, fcs_next;
  logic [2:0]  ones_run, ones_run_next;
  logic        line_level, line_level_next;
  logic        frame_open, frame_open_next;

  // Step control.
  logic        step_en, item_done, load, frame_end;
  logic [15:0] fcs_base;
  logic        open_eff;

  // Current emission.
  logic [7:0]  cur_byte;
  logic        is_flag, cur_bit, level_out, byte_end, stuff_set, esc_set;
  logic [2:0]  run_inc;
  logic [7:0]  emit_value;
  logic        emit_char;

  // The serialiser advances whenever the result register is empty or is being taken.
  assign step_en    = busy && (!result_valid || !result_stall);
  assign data_stall = busy && !(step_en && item_done);
  assign load       = data_valid && !data_stall;
  assign frame_end  = step_en && item_done && work_last;

  // An item taken in the cycle a frame closes starts a fresh frame.
  assign fcs_base = frame_end ? FCS_PRESET : fcs;
  assign open_eff = frame_open && !frame_end;

  // Output side of the serialiser: what goes out this cycle and whether the byte ends.
  always_comb begin
    unique case (phase)
      PH_OPEN:   cur_byte = FLAG_CHAR;
      PH_DATA:   cur_byte = work_byte;
      PH_FCS_LO: cur_byte = ~fcs[7:0];
      PH_FCS_HI: cur_byte = ~fcs[15:8];
      PH_CLOSE:  cur_byte = FLAG_CHAR;
      default:   cur_byte = FLAG_CHAR;
    endcase
    is_flag    = (phase == PH_OPEN) || (phase == PH_CLOSE);
    cur_bit    = cur_byte[bit_idx];
    run_inc    = ones_run + 3'd1;
    level_out  = line_level;
    byte_end   = 1'b0;
    stuff_set  = 1'b0;
    esc_set    = 1'b0;
    emit_value = 8'h00;
    emit_char  = 1'b0;
    if (mode == MODE_ASYNC) begin
      emit_char = 1'b1;
      if (esc_pending) begin
        emit_value = cur_byte ^ ESC_XOR;
        byte_end   = 1'b1;
      end else if (!is_flag && (cur_byte == FLAG_CHAR || cur_byte == ESC_CHAR)) begin
        emit_value = ESC_CHAR;
        esc_set    = 1'b1;
      end else begin
        emit_value = cur_byte;
        byte_end   = 1'b1;
      end
    end else begin
      if (stuff_pending) begin
        // A stuffed zero toggles the line; the byte ends here if its bits are all out.
        level_out = ~line_level;
        byte_end  = (bit_idx == 3'd0);
      end else begin
        level_out = cur_bit ? line_level : ~line_level;
        stuff_set = !is_flag && cur_bit && (run_inc >= STUFF_RUN);
        byte_end  = (bit_idx == 3'd7) && !stuff_set;
      end
      emit_value = {7'b0000000, level_out};
    end
    item_done = byte_end && ((phase == PH_DATA && !work_last) || phase == PH_CLOSE);
  end

  // Next state of the serialiser and the frame.
  always_comb begin
    busy_next          = busy;
    phase_next         = phase;
    bit_idx_next       = bit_idx;
    stuff_pending_next = stuff_pending;
    esc_pending_next   = esc_pending;
    fcs_next           = fcs;
    ones_run_next      = ones_run;
    line_level_next    = line_level;
    frame_open_next    = frame_open;
    if (step_en) begin
      line_level_next    = level_out;
      stuff_pending_next = stuff_set;
      esc_pending_next   = esc_set;
      if (mode == MODE_SYNC && !stuff_pending) begin
        bit_idx_next = bit_idx + 3'd1;
        if (!is_flag) begin
          ones_run_next = (cur_bit && !stuff_set) ? run_inc : 3'd0;
        end
      end
      if (byte_end) begin
        unique case (phase)
          PH_OPEN: begin
            phase_next    = PH_DATA;
            ones_run_next = 3'd0;
          end
          PH_DATA: begin
            if (work_last) begin
              phase_next = PH_FCS_LO;
            end
          end
          PH_FCS_LO: phase_next = PH_FCS_HI;
          PH_FCS_HI: phase_next = PH_CLOSE;
          PH_CLOSE:  phase_next = PH_CLOSE;
          default:   phase_next = PH_OPEN;
        endcase
      end
      if (item_done) begin
        busy_next = 1'b0;
        if (work_last) begin
          fcs_next        = FCS_PRESET;
          ones_run_next   = 3'd0;
          frame_open_next = 1'b0;
        end
      end
    end
    if (load) begin
      busy_next       = 1'b1;
      fcs_next        = fcs_byte(fcs_base, data_byte);
      phase_next      = open_eff ? PH_DATA : PH_OPEN;
      frame_open_next = 1'b1;
      bit_idx_next    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SYNC;
      busy          <= 1'b0;
      phase         <= PH_OPEN;
      bit_idx       <= 3'd0;
      stuff_pending <= 1'b0;
      esc_pending   <= 1'b0;
      fcs           <= FCS_PRESET;
      ones_run      <= 3'd0;
      line_level    <= 1'b0;
      frame_open    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      busy          <= busy_next;
      phase         <= phase_next;
      bit_idx       <= bit_idx_next;
      stuff_pending <= stuff_pending_next;
      esc_pending   <= esc_pending_next;
      fcs           <= fcs_next;
      ones_run      <= ones_run_next;
      line_level    <= line_level_next;
      frame_open    <= frame_open_next;
      result_valid  <= step_en || (result_valid && result_stall);
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      work_byte <= data_byte;
      work_last <= last_byte;
    end
    if (step_en) begin
      out_value   <= emit_value;
      out_is_char <= emit_char;
      out_last    <= item_done;
    end
  end

endmodule

// ----- design/hdlc_frame_transmitter_checker.sv -----
`include "hdlc_frame_transmitter_defines.svh"

module hdlc_frame_transmitter_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_value,
  input logic       out_is_char,
  input logic       out_last
);
  import hdlc_pkg::*;

  // A line bit carries the level in bit 0 only.
  `HFT_ASSERT_HOLD(a_line_bit_narrow, result_valid && !out_is_char, out_value[7:1] == 7'd0, "line bit with upper bits set")
  // An escape character is always followed by its partner, so it never ends an item.
  `HFT_ASSERT_HOLD(a_escape_not_last, result_valid && out_is_char && out_value == ESC_CHAR, !out_last, "escape character marked last")
  // Nothing is offered in the cycle after reset.
  `HFT_ASSERT_HOLD(a_idle_after_reset, $past(rst), !result_valid, "result offered straight after reset")
  // A stalled result stays put.
  `HFT_ASSERT_NEXT(a_stall_holds, result_valid && result_stall, result_valid && $stable(out_value) && $stable(out_last), "stalled result changed")

endmodule

bind hdlc_frame_transmitter hdlc_frame_transmitter_checker u_checker (.*);
